>>> src/spiq_pkg.sv
// Package for the quad SPI shift engine: item types, format word and
// shared counter helpers. No dependencies.
`default_nettype none

package spiq_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned CountW = 20;
  localparam logic [WordW-1:0] RxFill = 32'h5757_5757;

  typedef enum logic [1:0] {
    ACT_LOAD    = 2'd0,
    ACT_ARM_RX  = 2'd1,
    ACT_ARM_FDX = 2'd2,
    ACT_TICK    = 2'd3
  } action_t;

  typedef struct packed {
    logic [1:0] wt;
    logic [4:0] bpw;
    logic       lsb;
    logic       quad;
  } fmt_t;

  typedef struct packed {
    action_t           action;
    logic [WordW-1:0]  tx_word;
    logic [CountW-1:0] bit_count;
    logic              quad_mode;
    logic              lsb_order;
    logic [4:0]        bits_per_word_minus_one;
    logic [1:0]        words_per_transfer_log2;
    logic [3:0]        rx_lines;
  } in_item_t;

  typedef struct packed {
    logic             accepted;
    logic [3:0]       line_drive;
    logic [3:0]       line_enable;
    logic             rx_word_valid;
    logic [WordW-1:0] rx_word;
    logic             tx_busy;
    logic             rx_busy;
  } out_item_t;

  typedef struct packed {
    logic [5:0] counter;
    logic [4:0] offset;
    logic [2:0] subs;
    logic       done;
  } adv_t;

  // Lowest bit position of the current bit or nibble, modulo 32.
  function automatic logic [4:0] base_pos(fmt_t f, logic [4:0] offset, logic [5:0] counter);
    logic [4:0] idx;
    if (f.lsb) begin
      idx = offset + counter[4:0];
    end else begin
      idx = offset + f.bpw - counter[4:0] - (f.quad ? 5'd3 : 5'd0);
    end
    return idx;
  endfunction

  // Step the subword counters by n bits; done flags a finished word.
  function automatic adv_t advance(fmt_t f, logic [5:0] counter, logic [4:0] offset,
                                   logic [2:0] subs, logic [2:0] n);
    adv_t       r;
    logic [2:0] target;
    r.counter = counter + {3'd0, n};
    r.offset  = offset;
    r.subs    = subs;
    r.done    = 1'b0;
    if (r.counter >= {1'b0, f.bpw} + 6'd1) begin
      r.counter = '0;
      case (f.wt)
        2'd0:    r.offset = offset;
        2'd1:    r.offset = offset + 5'd16;
        default: r.offset = offset + 5'd8;
      endcase
      r.subs = subs + 3'd1;
      case (f.wt)
        2'd0:    target = 3'd1;
        2'd1:    target = 3'd2;
        default: target = 3'd4;
      endcase
      if (r.subs >= target) begin
        r.subs   = '0;
        r.offset = '0;
        r.done   = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/spiq_in_if.sv
// Input channel of the quad SPI shift engine: valid/ready plus one item.
// Depends on spiq_pkg.
`default_nettype none

interface spiq_in_if;
  import spiq_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> src/spiq_out_if.sv
// Result channel of the quad SPI shift engine: valid/ready plus one item.
// Depends on spiq_pkg.
`default_nettype none

interface spiq_out_if;
  import spiq_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> src/spi_quad_word_shift_engine_top.sv
// Quad SPI shift engine, top level: state, per-item logic, result register.
// Depends on spiq_pkg, spiq_in_if and spiq_out_if.
//
//  channel  | dir | carries
//  ---------+-----+-------------------------------------------------------
//  in_ch    | in  | action, tx word, bit count, word format, rx line sample
//  out_ch   | out | accepted, line drive/enable, rx word, tx/rx busy flags
//
// One item per clock while in_ch.ready is high. An accepted item updates
// the engine state and the output register at the same edge.
// The output register is the only stage: in_ch.ready stays high while the
// result is free or being taken, so a stall downstream holds just one item.
// Reset clears all counters, the format and the result valid; the receive
// word refills with 0x57575757.
`default_nettype none

module spi_quad_word_shift_engine_top (
  input  wire logic clk,
  input  wire logic rst,
  spiq_in_if.sink   in_ch,
  spiq_out_if.source out_ch
);
  import spiq_pkg::*;

  // Engine state
  logic [WordW-1:0]  shift_out_word;
  logic [CountW-1:0] tx_remaining;
  logic [5:0]        tx_bit_counter;
  logic [4:0]        tx_offset;
  logic [2:0]        tx_subword_count;
  logic [WordW-1:0]  shift_in_word;
  logic [CountW-1:0] rx_remaining;
  logic [5:0]        rx_bit_counter;
  logic [4:0]        rx_offset;
  logic [2:0]        rx_subword_count;
  logic              full_duplex;
  fmt_t              format_latched;

  logic [WordW-1:0]  shift_out_word_next;
  logic [CountW-1:0] tx_remaining_next;
  logic [5:0]        tx_bit_counter_next;
  logic [4:0]        tx_offset_next;
  logic [2:0]        tx_subword_count_next;
  logic [WordW-1:0]  shift_in_word_next;
  logic [CountW-1:0] rx_remaining_next;
  logic [5:0]        rx_bit_counter_next;
  logic [4:0]        rx_offset_next;
  logic [2:0]        rx_subword_count_next;
  logic              full_duplex_next;
  fmt_t              format_latched_next;

  // Result register
  logic      out_valid;
  out_item_t out_data;
  out_item_t res;

  logic in_fire;

  assign in_ch.ready  = !out_valid || out_ch.ready;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

  always_comb begin
    fmt_t       fmt_in;
    logic [2:0] n;
    logic [4:0] pos;
    logic [4:0] p;
    logic [3:0] sample;
    adv_t       adv;

    shift_out_word_next   = shift_out_word;
    tx_remaining_next     = tx_remaining;
    tx_bit_counter_next   = tx_bit_counter;
    tx_offset_next        = tx_offset;
    tx_subword_count_next = tx_subword_count;
    shift_in_word_next    = shift_in_word;
    rx_remaining_next     = rx_remaining;
    rx_bit_counter_next   = rx_bit_counter;
    rx_offset_next        = rx_offset;
    rx_subword_count_next = rx_subword_count;
    full_duplex_next      = full_duplex;
    format_latched_next   = format_latched;
    res                   = '0;

    fmt_in.quad = in_ch.data.quad_mode;
    fmt_in.lsb  = in_ch.data.lsb_order;
    fmt_in.bpw  = in_ch.data.bits_per_word_minus_one;
    fmt_in.wt   = in_ch.data.words_per_transfer_log2;

    n      = format_latched.quad ? 3'd4 : 3'd1;
    sample = format_latched.quad ? in_ch.data.rx_lines : {3'b000, in_ch.data.rx_lines[1]};
    pos    = '0;
    p      = '0;
    adv    = '0;

    unique case (in_ch.data.action)
      ACT_LOAD: begin
        if (tx_remaining == '0) begin
          res.accepted          = 1'b1;
          shift_out_word_next   = in_ch.data.tx_word;
          tx_remaining_next     = in_ch.data.bit_count;
          format_latched_next   = fmt_in;
          tx_bit_counter_next   = '0;
          tx_offset_next        = '0;
          tx_subword_count_next = '0;
        end
      end
      ACT_ARM_RX, ACT_ARM_FDX: begin
        if (tx_remaining == '0) begin
          res.accepted          = 1'b1;
          rx_remaining_next     = in_ch.data.bit_count;
          format_latched_next   = fmt_in;
          rx_bit_counter_next   = '0;
          rx_offset_next        = '0;
          rx_subword_count_next = '0;
          full_duplex_next      = (in_ch.data.action == ACT_ARM_FDX);
        end
      end
      ACT_TICK: begin
        // Sample first, so the receive side sees the pre-tick tx count
        if (rx_remaining != '0 && (tx_remaining == '0 || full_duplex)) begin
          pos = base_pos(format_latched, rx_offset, rx_bit_counter);
          for (int i = 0; i < 4; i++) begin
            p = pos + 5'(i);
            if (i == 0 || format_latched.quad) begin
              shift_in_word_next[p] = sample[i];
            end
          end
          rx_remaining_next = (rx_remaining > {17'd0, n}) ?
                              rx_remaining - {17'd0, n} : '0;
          adv = advance(format_latched, rx_bit_counter, rx_offset, rx_subword_count, n);
          rx_bit_counter_next   = adv.counter;
          rx_offset_next        = adv.offset;
          rx_subword_count_next = adv.subs;
          if (adv.done) begin
            res.rx_word_valid  = 1'b1;
            res.rx_word        = shift_in_word_next;
            shift_in_word_next = RxFill;
          end
          if (rx_remaining_next == '0) begin
            full_duplex_next = 1'b0;
          end
        end
        if (tx_remaining != '0) begin
          pos = base_pos(format_latched, tx_offset, tx_bit_counter);
          for (int i = 0; i < 4; i++) begin
            p = pos + 5'(i);
            if (i == 0 || format_latched.quad) begin
              res.line_drive[i] = shift_out_word[p];
            end
          end
          res.line_enable = format_latched.quad ? 4'hF : 4'h1;
          adv = advance(format_latched, tx_bit_counter, tx_offset, tx_subword_count, n);
          tx_bit_counter_next   = adv.counter;
          tx_offset_next        = adv.offset;
          tx_subword_count_next = adv.subs;
          tx_remaining_next = (tx_remaining > {17'd0, n}) ?
                              tx_remaining - {17'd0, n} : '0;
        end
      end
      default: ;
    endcase

    res.tx_busy = (tx_remaining_next != '0);
    res.rx_busy = (rx_remaining_next != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_out_word   <= '0;
      tx_remaining     <= '0;
      tx_bit_counter   <= '0;
      tx_offset        <= '0;
      tx_subword_count <= '0;
      shift_in_word    <= RxFill;
      rx_remaining     <= '0;
      rx_bit_counter   <= '0;
      rx_offset        <= '0;
      rx_subword_count <= '0;
      full_duplex      <= 1'b0;
      format_latched   <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (in_fire) begin
        shift_out_word   <= shift_out_word_next;
        tx_remaining     <= tx_remaining_next;
        tx_bit_counter   <= tx_bit_counter_next;
        tx_offset        <= tx_offset_next;
        tx_subword_count <= tx_subword_count_next;
        shift_in_word    <= shift_in_word_next;
        rx_remaining     <= rx_remaining_next;
        rx_bit_counter   <= rx_bit_counter_next;
        rx_offset        <= rx_offset_next;
        rx_subword_count <= rx_subword_count_next;
        full_duplex      <= full_duplex_next;
        format_latched   <= format_latched_next;
        out_valid        <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload: no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data <= res;
    end
  end

`ifndef SYNTH
  // A load arriving while transmit is busy must come back refused
  a_busy_refuse: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_ch.data.action == ACT_LOAD && tx_remaining != '0)
    |=> (out_valid && !out_data.accepted && out_data.tx_busy))
    else $error("load taken while transmit busy");

  // Nothing driven means no drive bits
  a_drive_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.line_enable == 4'h0) |-> (out_data.line_drive == 4'h0))
    else $error("line drive without enable");

  // Line enable is single, quad or off
  a_enable_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.line_enable == 4'h0 || out_data.line_enable == 4'h1 ||
                   out_data.line_enable == 4'hF))
    else $error("bad line enable");

  // A given receive word restarts the fill pattern
  a_rx_refill: assert property (@(posedge clk) disable iff (rst)
    (in_fire && res.rx_word_valid) |=> (shift_in_word == RxFill))
    else $error("receive word not refilled");
`endif

endmodule

`default_nettype wire

>>> tb/tb.sv
// Self-checking bench for spi_quad_word_shift_engine_top: directed and random items,
// with a shadow model of the shift engine held in a small scoreboard class.
// Depends on spiq_pkg, spiq_in_if, spiq_out_if and the RTL top level.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spiq_pkg::*;

  localparam int unsigned Period     = 10;
  localparam int unsigned CycleLimit = 400000;  // far above the slowest legal run
  localparam int unsigned ItemTarget = 1600;
  localparam int unsigned SettleWait = 8;       // one result register, so a short settle is enough

  // Position of one direction inside its 32-bit word: bit counter within
  // the subword, offset of the subword, subwords done, word-complete flag.
  typedef struct packed {
    logic [5:0] cnt;
    logic [4:0] off;
    logic [2:0] subs;
    logic       done;
  } lane_t;

  // Shadow of the engine. take_item() works out the result of an accepted
  // item and queues it; match_result() compares what the block gives back.
  class shift_engine_tracker;
    fmt_t        fmt;
    logic [31:0] tx_word_q;
    logic [31:0] rx_shift;
    logic [19:0] tx_left;
    logic [19:0] rx_left;
    lane_t       tx_lane;
    lane_t       rx_lane;
    logic        duplex;
    out_item_t   due[$];
    int unsigned faults, ticks, taken, refused, words_out, checked;

    function new();
      fmt       = '0;
      tx_word_q = '0;
      rx_shift  = RxFill;
      tx_left   = '0;
      rx_left   = '0;
      tx_lane   = '0;
      rx_lane   = '0;
      duplex    = 1'b0;
      faults    = 0;
      ticks     = 0;
      taken     = 0;
      refused   = 0;
      words_out = 0;
      checked   = 0;
    endfunction

    // Lowest bit of the current bit or nibble; wraps modulo 32.
    function logic [4:0] low_bit(lane_t l);
      if (fmt.lsb) return l.off + l.cnt[4:0];
      return l.off + fmt.bpw - l.cnt[4:0] - (fmt.quad ? 5'd3 : 5'd0);
    endfunction

    // Move a lane on by n bits; a subword ends once the counter reaches
    // or passes the subword length.
    function lane_t step_lane(lane_t l, int unsigned n);
      lane_t      r;
      logic [2:0] goal;
      r      = l;
      r.done = 1'b0;
      r.cnt  = l.cnt + 6'(n);
      if (r.cnt > {1'b0, fmt.bpw}) begin
        r.cnt  = '0;
        r.off  = l.off + (fmt.wt == 2'd0 ? 5'd0 : (fmt.wt == 2'd1 ? 5'd16 : 5'd8));
        r.subs = l.subs + 3'd1;
        goal   = fmt.wt == 2'd0 ? 3'd1 : (fmt.wt == 2'd1 ? 3'd2 : 3'd4);
        if (r.subs >= goal) begin
          r.subs = '0;
          r.off  = '0;
          r.done = 1'b1;
        end
      end
      return r;
    endfunction

    function out_item_t take_item(in_item_t it);
      out_item_t   r;
      logic [4:0]  pos;
      logic [4:0]  q;
      logic [3:0]  lines_in;
      int unsigned n;
      r = '0;
      if (it.action == ACT_TICK) begin
        ticks++;
        n = fmt.quad ? 4 : 1;
        // sample first, and only when the receive side may run
        if (rx_left != 0 && (tx_left == 0 || duplex)) begin
          lines_in = fmt.quad ? it.rx_lines : {3'b000, it.rx_lines[1]};
          pos = low_bit(rx_lane);
          for (int i = 0; i < n; i++) begin
            q = pos + 5'(i);
            rx_shift[q] = lines_in[i];
          end
          rx_left = (rx_left > n) ? rx_left - 20'(n) : '0;
          rx_lane = step_lane(rx_lane, n);
          if (rx_lane.done) begin
            r.rx_word_valid = 1'b1;
            r.rx_word       = rx_shift;
            rx_shift        = RxFill;
            words_out++;
          end
          if (rx_left == 0) duplex = 1'b0;
        end
        if (tx_left != 0) begin
          pos = low_bit(tx_lane);
          for (int i = 0; i < n; i++) begin
            q = pos + 5'(i);
            r.line_drive[i] = tx_word_q[q];
          end
          r.line_enable = fmt.quad ? 4'hf : 4'h1;
          tx_lane = step_lane(tx_lane, n);
          tx_left = (tx_left > n) ? tx_left - 20'(n) : '0;
        end
      end else if (tx_left != 0) begin
        refused++;
      end else begin
        taken++;
        r.accepted = 1'b1;
        // one format for both directions: the latest load or arm wins
        fmt.quad = it.quad_mode;
        fmt.lsb  = it.lsb_order;
        fmt.bpw  = it.bits_per_word_minus_one;
        fmt.wt   = it.words_per_transfer_log2;
        if (it.action == ACT_LOAD) begin
          tx_word_q = it.tx_word;
          tx_left   = it.bit_count;
          tx_lane   = '0;
        end else begin
          rx_left = it.bit_count;
          rx_lane = '0;
          duplex  = (it.action == ACT_ARM_FDX);
        end
      end
      r.tx_busy = (tx_left != 0);
      r.rx_busy = (rx_left != 0);
      due.push_back(r);
      return r;
    endfunction

    function void report(string what, logic [31:0] want, logic [31:0] got);
      faults++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    endfunction

    function void match_result(out_item_t got);
      out_item_t want;
      checked++;
      if (due.size() == 0) begin
        faults++;
        $display("%0t ns: result with nothing expected, actual %h", $time, got);
        return;
      end
      want = due.pop_front();
      if (got.accepted !== want.accepted)
        report("accepted", 32'(want.accepted), 32'(got.accepted));
      if (got.line_drive !== want.line_drive)
        report("line_drive", 32'(want.line_drive), 32'(got.line_drive));
      if (got.line_enable !== want.line_enable)
        report("line_enable", 32'(want.line_enable), 32'(got.line_enable));
      if (got.rx_word_valid !== want.rx_word_valid)
        report("rx_word_valid", 32'(want.rx_word_valid), 32'(got.rx_word_valid));
      if (got.rx_word !== want.rx_word)
        report("rx_word", want.rx_word, got.rx_word);
      if (got.tx_busy !== want.tx_busy)
        report("tx_busy", 32'(want.tx_busy), 32'(got.tx_busy));
      if (got.rx_busy !== want.rx_busy)
        report("rx_busy", 32'(want.rx_busy), 32'(got.rx_busy));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  spiq_in_if  in_ch ();
  spiq_out_if out_ch ();

  spi_quad_word_shift_engine_top dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #(Period / 2) clk = ~clk;

  shift_engine_tracker sb = new();

  int unsigned useful     = 0;  // items that load, arm or tick (refusals not counted)
  int          burst_left = 1;
  int unsigned cycles     = 0;

  // --------------------------------------------------------------------
  // Watchdog: a hung handshake or a lost result ends the run here.
  // --------------------------------------------------------------------
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("spi_quad_word_shift_engine_top test failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------
  // Receiver. Checks every result taken at this edge, then picks ready
  // for the next cycle. Stall behaviour changes in stretches: always
  // ready, coin toss, rare stalls, mostly stalled. Once in the run it
  // holds off for a long stretch so the result register fills and the
  // input side backs up while the sender keeps offering items.
  // --------------------------------------------------------------------
  int unsigned rx_mode      = 0;
  int unsigned rx_mode_left = 0;
  int unsigned hold_left    = 0;
  bit          held_once    = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) sb.match_result(out_ch.data);
      if (rx_mode_left == 0) begin
        rx_mode      = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(16, 160);
      end else begin
        rx_mode_left--;
      end
      if (!held_once && sb.checked >= 300) begin
        held_once = 1'b1;
        hold_left = 250;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (rx_mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= 1'($urandom_range(0, 1));
          2:       out_ch.ready <= ($urandom_range(0, 7) != 0);
          default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------
  // Item construction. Fields an action does not use are still random,
  // so the block is also seen to ignore them.
  // --------------------------------------------------------------------
  function automatic in_item_t rand_item(action_t a);
    in_item_t it;
    it.action                  = a;
    it.tx_word                 = $urandom;
    it.bit_count               = 20'($urandom);
    it.quad_mode               = 1'($urandom);
    it.lsb_order               = 1'($urandom);
    it.bits_per_word_minus_one = 5'($urandom);
    it.words_per_transfer_log2 = 2'($urandom);
    it.rx_lines                = 4'($urandom);
    return it;
  endfunction

  function automatic in_item_t shaped(action_t a, fmt_t f, int unsigned c);
    in_item_t it;
    it                         = rand_item(a);
    it.bit_count               = 20'(c);
    it.quad_mode               = f.quad;
    it.lsb_order               = f.lsb;
    it.bits_per_word_minus_one = f.bpw;
    it.words_per_transfer_log2 = f.wt;
    return it;
  endfunction

  // Mostly the usual subword sizes; the unused subword code turns up now and then.
  function automatic fmt_t rand_fmt();
    fmt_t f;
    f.quad = 1'($urandom);
    f.lsb  = 1'($urandom);
    case ($urandom_range(0, 3))
      0:       f.bpw = 5'd7;
      1:       f.bpw = 5'd15;
      2:       f.bpw = 5'd31;
      default: f.bpw = 5'($urandom);
    endcase
    f.wt = ($urandom_range(0, 7) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    return f;
  endfunction

  // Bits in one full word of format f.
  function automatic int unsigned word_bits(fmt_t f);
    return (f.bpw + 1) * (f.wt == 2'd0 ? 1 : (f.wt == 2'd1 ? 2 : 4));
  endfunction

  // Mostly whole receive words, sometimes a ragged count.
  function automatic int unsigned rx_count(fmt_t f);
    if ($urandom_range(0, 3) == 0) return $urandom_range(1, 2 * word_bits(f));
    return word_bits(f) * $urandom_range(1, 2);
  endfunction

  // Transmit lengths stay short so the refusal window never gets long;
  // above 32 the latched word is sent round again.
  function automatic int unsigned tx_count();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return $urandom_range(33, 200);
      default: return $urandom_range(1, 70);
    endcase
  endfunction

  // --------------------------------------------------------------------
  // Sender. Offers one item and waits for the handshake; the shadow model
  // is updated at the accepting edge, so stimulus built afterwards can see
  // the current busy state. Bursts of random length with random gaps.
  // --------------------------------------------------------------------
  task automatic push(in_item_t it);
    out_item_t   want;
    int unsigned gap;
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    want = sb.take_item(it);
    if (it.action == ACT_TICK || want.accepted) useful++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 48);
      gap        = $urandom_range(0, 6);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic go(action_t a, logic [31:0] w, logic [19:0] c, logic q, logic l,
                    logic [4:0] b, logic [1:0] wt, logic [3:0] lines);
    in_item_t it;
    it.action                  = a;
    it.tx_word                 = w;
    it.bit_count               = c;
    it.quad_mode               = q;
    it.lsb_order               = l;
    it.bits_per_word_minus_one = b;
    it.words_per_transfer_log2 = wt;
    it.rx_lines                = lines;
    push(it);
  endtask

  task automatic tick();
    push(rand_item(ACT_TICK));
  endtask

  // Ticks until the transmit side is free again, so a load or arm can land.
  task automatic drain_tx();
    while (sb.tx_left != 0) tick();
  endtask

  // Ticks until both directions are done, then a few idle ticks.
  task automatic run_out();
    while (sb.tx_left != 0 || sb.rx_left != 0) tick();
    repeat ($urandom_range(0, 2)) tick();
  endtask

  // --------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------
  initial begin
    fmt_t        f;
    int unsigned pick;
    rst           = 1'b1;
    in_ch.valid   = 1'b0;
    in_ch.data    = '0;
    out_ch.ready  = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part.
    // Idle tick: nothing armed, nothing loaded.
    go(ACT_TICK, 32'h0, 20'h0, 1'b0, 1'b0, 5'd0, 2'd0, 4'hf);
    // Zero-length load is taken and leaves transmit idle.
    go(ACT_LOAD, 32'hffff_ffff, 20'h0, 1'b0, 1'b1, 5'd31, 2'd0, 4'h0);
    // Full-duplex arm, longest count, unused subword code.
    go(ACT_ARM_FDX, 32'h0, 20'hfffff, 1'b1, 1'b1, 5'd31, 2'd3, 4'h0);
    // Load during the receive replaces the shared format; msb-first nibble
    // with a two-bit subword wraps past bit 0.
    go(ACT_LOAD, 32'ha5c3_0f96, 20'd8, 1'b1, 1'b0, 5'd1, 2'd0, 4'h0);
    // Both refused while transmit is busy.
    go(ACT_LOAD, 32'h0, 20'hfffff, 1'b0, 1'b0, 5'd0, 2'd0, 4'h0);
    go(ACT_ARM_RX, 32'h0, 20'd5, 1'b0, 1'b0, 5'd0, 2'd0, 4'h0);
    go(ACT_TICK, 32'h0, 20'h0, 1'b0, 1'b0, 5'd0, 2'd0, 4'hf);
    go(ACT_TICK, 32'h0, 20'h0, 1'b0, 1'b0, 5'd0, 2'd0, 4'h0);
    // Quad step larger than the count left: count saturates, partial word kept.
    go(ACT_ARM_RX, 32'h0, 20'd3, 1'b1, 1'b0, 5'd3, 2'd1, 4'h0);
    go(ACT_TICK, 32'h0, 20'h0, 1'b0, 1'b0, 5'd0, 2'd0, 4'ha);
    // Single-line receive samples line 1 only.
    go(ACT_ARM_RX, 32'h0, 20'd2, 1'b0, 1'b0, 5'd0, 2'd2, 4'h0);
    go(ACT_TICK, 32'h0, 20'h0, 1'b0, 1'b0, 5'd0, 2'd0, 4'h2);
    go(ACT_TICK, 32'h0, 20'h0, 1'b0, 1'b0, 5'd0, 2'd0, 4'hd);
    // Four one-bit subwords at step 8 complete a word.
    go(ACT_ARM_RX, 32'h0, 20'd4, 1'b0, 1'b1, 5'd0, 2'd3, 4'h0);
    go(ACT_TICK, 32'h0, 20'h0, 1'b0, 1'b0, 5'd0, 2'd0, 4'h2);
    go(ACT_TICK, 32'h0, 20'h0, 1'b0, 1'b0, 5'd0, 2'd0, 4'h0);
    go(ACT_TICK, 32'h0, 20'h0, 1'b0, 1'b0, 5'd0, 2'd0, 4'h2);
    go(ACT_TICK, 32'h0, 20'h0, 1'b0, 1'b0, 5'd0, 2'd0, 4'h0);
    // Msb-first single bits from the top of a 32-bit subword.
    go(ACT_LOAD, 32'h8000_0001, 20'd2, 1'b0, 1'b0, 5'd31, 2'd1, 4'h0);
    go(ACT_TICK, 32'h0, 20'h0, 1'b0, 1'b0, 5'd0, 2'd0, 4'h0);
    go(ACT_TICK, 32'h0, 20'h0, 1'b0, 1'b0, 5'd0, 2'd0, 4'h0);
    // Receive-only after transmit went idle, then a tick with nothing left.
    go(ACT_ARM_RX, 32'h0, 20'd1, 1'b0, 1'b0, 5'd31, 2'd0, 4'h0);
    go(ACT_TICK, 32'h0, 20'h0, 1'b0, 1'b0, 5'd0, 2'd0, 4'h2);
    go(ACT_TICK, 32'h0, 20'h0, 1'b0, 1'b0, 5'd0, 2'd0, 4'h2);

    // Random part: mostly well-formed transfers with random content,
    // the rest noise that includes refusals and long receive counts.
    while (useful < ItemTarget) begin
      pick = $urandom_range(0, 9);
      f    = rand_fmt();
      if (pick <= 7) drain_tx();
      case (pick)
        0, 1, 2: begin  // transmit only
          push(shaped(ACT_LOAD, f, tx_count()));
          while (sb.tx_left != 0) tick();
        end
        3, 4: begin     // receive only
          push(shaped(ACT_ARM_RX, f, rx_count(f)));
          run_out();
        end
        5, 6: begin     // full duplex, sometimes with the load changing the format
          push(shaped(ACT_ARM_FDX, f, rx_count(f)));
          if ($urandom_range(0, 3) == 0) f = rand_fmt();
          push(shaped(ACT_LOAD, f, tx_count()));
          run_out();
        end
        7: begin        // plain receive armed first, held back until transmit ends
          push(shaped(ACT_ARM_RX, f, rx_count(f)));
          push(shaped(ACT_LOAD, f, tx_count()));
          run_out();
        end
        default: begin  // noise
          repeat ($urandom_range(1, 6)) begin
            in_item_t it;
            it = rand_item(action_t'($urandom_range(0, 3)));
            // an accepted load must stay short; arms and refused loads need not
            if (it.action == ACT_LOAD && sb.tx_left == 0) it.bit_count = 20'(tx_count());
            push(it);
          end
        end
      endcase
    end

    in_ch.valid <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk);
    repeat (SettleWait) @(posedge clk);

    $display("Covered %0d ticks, %0d loads/arms taken, %0d refused while busy.",
             sb.ticks, sb.taken, sb.refused);
    $display("%0d receive words completed; %0d results checked, %0d mismatches.",
             sb.words_out, sb.checked, sb.faults);
    if (sb.faults == 0 && sb.due.size() == 0) begin
      $display("spi_quad_word_shift_engine_top test passed");
    end else begin
      $display("spi_quad_word_shift_engine_top test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
